// ===== rtl/core/rau_pkg.sv =====
// Package for the rational arithmetic unit: actions, status codes,
// sequencer states, divider request/response types and widths. No dependencies.
package rau_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned FIELD_W = 32;

  typedef enum logic [2:0] {
    ACT_NORM = 3'd0,
    ACT_ADD  = 3'd1,
    ACT_SUB  = 3'd2,
    ACT_MUL  = 3'd3,
    ACT_DIV  = 3'd4,
    ACT_CMP  = 3'd5,
    ACT_NEG  = 3'd6,
    ACT_RCP  = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERODEN = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_OVF     = 2'd3
  } status_t;

  // States of the unit's sequencer.
  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_GA,       // gcd of A
    S_DA,       // A num / g, A den / g
    S_GB,
    S_DB,
    S_PREP,     // choose action flow
    S_ADD_G,    // gcd of denominators
    S_ADD_DIV,  // ad = a.d/g, bd = b.d/g
    S_ADD_MUL,  // x = an*bd, y = bn*ad
    S_ADD_SUM,
    S_ADD_G2,
    S_ADD_DIV2, // t/g2, b.d/g2
    S_ADD_MUL2, // ad * (b.d/g2)
    S_MUL,      // numerator and denominator products
    S_CMP,
    S_FIN_G,    // gcd of final pair
    S_FIN_DIV,
    S_FIN_CHK,
    S_OUT
  } state_t;

  // Request to the shared divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [63:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/core/rau_if.sv =====
// Valid/ready channel interfaces for the rational arithmetic unit.
// Depends on rau_pkg.
interface rau_in_if import rau_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic        a_sign;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic        b_sign;
  logic [31:0] b_num;
  logic [31:0] b_den;
  modport source (output valid, action, a_sign, a_num, a_den, b_sign, b_num, b_den,
                  input ready);
  modport sink (input valid, action, a_sign, a_num, a_den, b_sign, b_num, b_den,
                output ready);
endinterface

interface rau_out_if import rau_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        r_sign;
  logic [31:0] r_num;
  logic [31:0] r_den;
  logic        greater;
  logic        equal;
  logic [1:0]  status;
  modport source (output valid, r_sign, r_num, r_den, greater, equal, status,
                  input ready);
  modport sink (input valid, r_sign, r_num, r_den, greater, equal, status,
                output ready);
endinterface

// ===== rtl/core/rational_arith_unit.sv =====
// Rational arithmetic unit: one transaction in, one reduced result out. Every gcd and
// exact division runs through one shared 64-bit divider, so a transaction is shortest
// for a zero denominator and grows longer with the number of Euclid steps, one
// division each, plus two divisions for each numerator and denominator pair that
// is divided exactly.
// Products use one 32x32 multiplier, one product per cycle. The unit takes
// no new transaction until the previous result has been taken.
// Depends on rau_pkg, rau_if and rau_divider.
module rational_arith_unit import rau_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);

  localparam logic [63:0] MAXV = (64'd1 << VALUE_WIDTH) - 64'd1;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;          // state to resume after a gcd
  logic [2:0]  act_r, act_nxt;
  logic        as_r, as_nxt, bs_r, bs_nxt;
  logic [63:0] an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  // gcd / scratch registers
  logic [63:0] ga_r, ga_nxt, gb_r, gb_nxt;
  logic [63:0] x_r, x_nxt, y_r, y_nxt, g_r, g_nxt;
  logic        rs_r, rs_nxt;
  logic [1:0]  phase_r, phase_nxt;
  // result
  logic        o_valid_r, o_valid_nxt;
  logic        o_sign_r, o_sign_nxt, o_gt_r, o_gt_nxt, o_eq_r, o_eq_nxt;
  logic [31:0] o_num_r, o_num_nxt, o_den_r, o_den_nxt;
  status_t     o_st_r, o_st_nxt;

  div_req_t dreq;
  div_rsp_t drsp;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [64:0] sum;

  rau_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
  assign in_ch.ready = (state_r == S_IDLE) && !o_valid_r;

  // Sequencer: operand reduction, action flow, final reduction.
  always_comb begin
    state_nxt = state_r; ret_nxt = ret_r; act_nxt = act_r;
    as_nxt = as_r; bs_nxt = bs_r;
    an_nxt = an_r; ad_nxt = ad_r; bn_nxt = bn_r; bd_nxt = bd_r;
    ga_nxt = ga_r; gb_nxt = gb_r; x_nxt = x_r; y_nxt = y_r; g_nxt = g_r;
    rs_nxt = rs_r; phase_nxt = phase_r;
    o_valid_nxt = o_valid_r; o_sign_nxt = o_sign_r; o_gt_nxt = o_gt_r;
    o_eq_nxt = o_eq_r; o_num_nxt = o_num_r; o_den_nxt = o_den_r; o_st_nxt = o_st_r;
    dreq = '0;
    mul_a = '0; mul_b = '0;
    sum = '0;
    if (o_valid_r && out_ch.ready) o_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          act_nxt = in_ch.action;
          as_nxt = in_ch.a_sign; bs_nxt = in_ch.b_sign;
          an_nxt = {32'd0, in_ch.a_num} & MAXV;
          ad_nxt = {32'd0, in_ch.a_den} & MAXV;
          bn_nxt = {32'd0, in_ch.b_num} & MAXV;
          bd_nxt = {32'd0, in_ch.b_den} & MAXV;
          o_sign_nxt = 1'b0; o_num_nxt = '0; o_den_nxt = 32'd1;
          o_gt_nxt = 1'b0; o_eq_nxt = 1'b0; o_st_nxt = ST_OK;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (ad_r == '0 || (!(act_r == ACT_NORM || act_r == ACT_NEG ||
            act_r == ACT_RCP) && bd_r == '0)) begin
          o_st_nxt = ST_ZERODEN;
          state_nxt = S_OUT;
        end else begin
          if (act_r == ACT_NORM || act_r == ACT_NEG || act_r == ACT_RCP) begin
            bs_nxt = 1'b0; bn_nxt = '0; bd_nxt = 64'd1;
          end
          if (an_r == '0) begin as_nxt = 1'b0; ad_nxt = 64'd1; end
          // A zero numerator reduces against the canonical denominator of one.
          ga_nxt = an_r; gb_nxt = (an_r == '0) ? 64'd1 : ad_r;
          ret_nxt = S_DA; state_nxt = S_GA; phase_nxt = 2'd0;
        end
      end
      // Euclid on (ga, gb) through the divider; resumes at ret.
      S_GA, S_GB, S_ADD_G, S_ADD_G2, S_FIN_G: begin
        if (phase_r == 2'd0) begin
          if (gb_r == '0) begin
            g_nxt = ga_r; state_nxt = ret_r;
          end else begin
            dreq.start = 1'b1; dreq.dividend = ga_r; dreq.divisor = gb_r;
            phase_nxt = 2'd1;
          end
        end else if (drsp.done) begin
          ga_nxt = gb_r; gb_nxt = drsp.rem; phase_nxt = 2'd0;
        end
      end
      // Exact divisions of a pair by g: x / g then y / g.
      S_DA, S_DB, S_ADD_DIV, S_ADD_DIV2, S_FIN_DIV: begin
        if (g_r == '0) g_nxt = 64'd1;
        else if (phase_r == 2'd0) begin
          dreq.start = 1'b1; dreq.divisor = g_r;
          unique case (state_r)
            S_DA: dreq.dividend = an_r;
            S_DB: dreq.dividend = bn_r;
            S_ADD_DIV: dreq.dividend = ad_r;
            S_ADD_DIV2: dreq.dividend = x_r;
            default: dreq.dividend = x_r;
          endcase
          phase_nxt = 2'd1;
        end else if (phase_r == 2'd1) begin
          if (drsp.done) begin
            unique case (state_r)
              S_DA: an_nxt = drsp.quo;
              S_DB: bn_nxt = drsp.quo;
              S_ADD_DIV: x_nxt = drsp.quo;
              default: x_nxt = drsp.quo;
            endcase
            phase_nxt = 2'd2;
          end
        end else if (phase_r == 2'd2) begin
          dreq.start = 1'b1; dreq.divisor = g_r;
          unique case (state_r)
            S_DA: dreq.dividend = ad_r;
            S_DB: dreq.dividend = bd_r;
            S_ADD_DIV: dreq.dividend = bd_r;
            S_ADD_DIV2: dreq.dividend = bd_r;
            default: dreq.dividend = y_r;
          endcase
          phase_nxt = 2'd3;
        end else if (drsp.done) begin
          phase_nxt = 2'd0;
          unique case (state_r)
            S_DA: begin
              ad_nxt = drsp.quo;
              if (bn_r == '0) begin bs_nxt = 1'b0; bd_nxt = 64'd1; end
              ga_nxt = bn_r; gb_nxt = (bn_r == '0) ? 64'd1 : bd_r;
              ret_nxt = S_DB; state_nxt = S_GB;
            end
            S_DB: begin bd_nxt = drsp.quo; state_nxt = S_PREP; end
            S_ADD_DIV: begin
              // x = ad', y = bd'
              y_nxt = drsp.quo; state_nxt = S_ADD_MUL;
            end
            S_ADD_DIV2: begin
              // x = t/g2, y = b.d/g2
              y_nxt = drsp.quo; state_nxt = S_ADD_MUL2;
            end
            default: begin
              if (drsp.quo > MAXV || x_r > MAXV || x_r == '0) begin
                o_st_nxt = ST_OVF;
              end
              o_sign_nxt = rs_r; o_num_nxt = x_r[31:0]; o_den_nxt = drsp.quo[31:0];
              state_nxt = S_FIN_CHK;
            end
          endcase
        end
      end
      S_PREP: begin
        if (act_r == ACT_SUB && bn_r != '0) bs_nxt = !bs_r;
        unique case (action_t'(act_r))
          ACT_NORM: begin rs_nxt = as_r; x_nxt = an_r; y_nxt = ad_r; state_nxt = S_FIN_CHK; end
          ACT_NEG: begin
            rs_nxt = (an_r != '0) ? !as_r : 1'b0;
            x_nxt = an_r; y_nxt = ad_r; state_nxt = S_FIN_CHK;
          end
          ACT_RCP: begin
            if (an_r == '0) begin o_st_nxt = ST_DIVZERO; state_nxt = S_OUT; end
            else begin rs_nxt = as_r; x_nxt = ad_r; y_nxt = an_r; state_nxt = S_FIN_CHK; end
          end
          ACT_ADD, ACT_SUB: begin
            if (an_r == '0) begin
              rs_nxt = (act_r == ACT_SUB && bn_r != '0) ? !bs_r : bs_r;
              x_nxt = bn_r; y_nxt = bd_r; state_nxt = S_FIN_CHK;
            end else if (bn_r == '0) begin
              rs_nxt = as_r; x_nxt = an_r; y_nxt = ad_r; state_nxt = S_FIN_CHK;
            end else begin
              ga_nxt = ad_r; gb_nxt = bd_r; ret_nxt = S_ADD_DIV;
              phase_nxt = 2'd0; state_nxt = S_ADD_G;
            end
          end
          ACT_MUL: begin
            if (an_r == '0 || bn_r == '0) state_nxt = S_OUT;
            else begin rs_nxt = as_r ^ bs_r; phase_nxt = 2'd0; state_nxt = S_MUL; end
          end
          ACT_DIV: begin
            if (bn_r == '0) begin o_st_nxt = ST_DIVZERO; state_nxt = S_OUT; end
            else begin
              if (an_r == '0) state_nxt = S_OUT;
              else begin
                bn_nxt = bd_r; bd_nxt = bn_r;
                rs_nxt = as_r ^ bs_r; phase_nxt = 2'd0; state_nxt = S_MUL;
              end
            end
          end
          default: begin phase_nxt = 2'd0; state_nxt = S_CMP; end
        endcase
      end
      S_ADD_MUL: begin
        // g_r holds gcd of dens; x = ad', y = bd'. Form an*bd' then bn*ad'.
        if (phase_r == 2'd0) begin
          mul_a = an_r[31:0]; mul_b = y_r[31:0];
          gb_nxt = mul_p; ga_nxt = x_r; phase_nxt = 2'd1;
        end else begin
          mul_a = bn_r[31:0]; mul_b = ga_r[31:0];
          x_nxt = gb_r; y_nxt = mul_p; ad_nxt = ga_r; phase_nxt = 2'd0;
          state_nxt = S_ADD_SUM;
        end
      end
      S_ADD_SUM: begin
        if (as_r == bs_r) begin
          sum = {1'b0, x_r} + {1'b0, y_r};
          rs_nxt = as_r;
        end else if (x_r >= y_r) begin
          sum = {1'b0, x_r} - {1'b0, y_r}; rs_nxt = as_r;
        end else begin
          sum = {1'b0, y_r} - {1'b0, x_r}; rs_nxt = bs_r;
        end
        if (sum[64]) begin o_st_nxt = ST_OVF; state_nxt = S_OUT; end
        else if (sum[63:0] == '0) state_nxt = S_OUT;
        else begin
          x_nxt = sum[63:0];
          ga_nxt = sum[63:0]; gb_nxt = g_r; ret_nxt = S_ADD_DIV2;
          state_nxt = S_ADD_G2;
        end
      end
      S_ADD_MUL2: begin
        // y = b.d/g2 (<= 32 bits), ad_r = ad'
        mul_a = ad_r[31:0]; mul_b = y_r[31:0];
        y_nxt = mul_p; state_nxt = S_FIN_CHK;
      end
      S_MUL: begin
        if (phase_r == 2'd0) begin
          mul_a = an_r[31:0]; mul_b = bn_r[31:0]; x_nxt = mul_p; phase_nxt = 2'd1;
        end else begin
          mul_a = ad_r[31:0]; mul_b = bd_r[31:0]; y_nxt = mul_p; phase_nxt = 2'd0;
          state_nxt = S_FIN_CHK;
        end
      end
      S_CMP: begin
        if (phase_r == 2'd0) begin
          mul_a = an_r[31:0]; mul_b = bd_r[31:0]; x_nxt = mul_p; phase_nxt = 2'd1;
        end else if (phase_r == 2'd1) begin
          mul_a = bn_r[31:0]; mul_b = ad_r[31:0]; y_nxt = mul_p; phase_nxt = 2'd2;
        end else begin
          phase_nxt = 2'd0;
          if (as_r != bs_r) begin o_gt_nxt = !as_r; o_eq_nxt = 1'b0; end
          else begin
            o_eq_nxt = (x_r == y_r);
            o_gt_nxt = as_r ? (x_r < y_r) : (x_r > y_r);
          end
          state_nxt = S_OUT;
        end
      end
      S_FIN_CHK: begin
        // First pass: start final reduction; re-entry after FIN_DIV finishes.
        if (ret_r == S_FIN_DIV) begin
          ret_nxt = S_IDLE; state_nxt = S_OUT;
          if (o_st_r == ST_OVF) begin
            o_sign_nxt = 1'b0; o_num_nxt = '0; o_den_nxt = 32'd1;
          end
        end else if (x_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          ga_nxt = x_r; gb_nxt = y_r; ret_nxt = S_FIN_DIV;
          phase_nxt = 2'd0; state_nxt = S_FIN_G;
        end
      end
      S_OUT: begin
        if (!o_valid_r) begin
          o_valid_nxt = 1'b1; ret_nxt = S_IDLE; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_r     <= S_IDLE;
      phase_r   <= 2'd0;
      o_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      phase_r   <= phase_nxt;
      o_valid_r <= o_valid_nxt;
    end
    act_r <= act_nxt; as_r <= as_nxt; bs_r <= bs_nxt;
    an_r <= an_nxt; ad_r <= ad_nxt; bn_r <= bn_nxt; bd_r <= bd_nxt;
    ga_r <= ga_nxt; gb_r <= gb_nxt; x_r <= x_nxt; y_r <= y_nxt; g_r <= g_nxt;
    rs_r <= rs_nxt;
    o_sign_r <= o_sign_nxt; o_gt_r <= o_gt_nxt; o_eq_r <= o_eq_nxt;
    o_num_r <= o_num_nxt; o_den_r <= o_den_nxt; o_st_r <= o_st_nxt;
  end

  assign out_ch.valid   = o_valid_r;
  assign out_ch.r_sign  = o_sign_r;
  assign out_ch.r_num   = o_num_r;
  assign out_ch.r_den   = o_den_r;
  assign out_ch.greater = o_gt_r;
  assign out_ch.equal   = o_eq_r;
  assign out_ch.status  = o_st_r;

  // A valid result is never a zero denominator.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r |-> o_den_r != '0) else $error("zero denominator on output");
  // Zero results are canonical.
  a_zero_canon: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_num_r == '0) |-> (!o_sign_r && o_den_r == 32'd1))
    else $error("noncanonical zero");
  // No new transaction while a result is pending.
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r |-> !in_ch.ready) else $error("accepted with result pending");

endmodule

// ===== rtl/core/rau_divider.sv =====
// Shared 64-bit restoring divider, one quotient bit per cycle while busy.
// Depends on rau_pkg.
module rau_divider import rau_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] quo_r, quo_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;

  // One shift-subtract step per cycle while busy.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[63]} - {1'b0, dvs_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

  // A finished division never overlaps a busy one.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> !busy_r) else $error("divider done while busy");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && !req.start) |=> cnt_r == $past(cnt_r)) else $error("counter moved while idle");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r) else $error("divider did not start");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for rational_arith_unit: directed table plus random transactions,
// each result checked against a typed table entry or a behavioral model of the
// reduced-fraction arithmetic. Depends on rau_pkg, rau_if and the unit's RTL.
`timescale 1ns / 100ps

module testbench;
  import rau_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH_DEF;
  localparam longint unsigned CYCLE_LIMIT = 64'd200_000_000;
  localparam int RANDOM_ITEMS = 1530;

  typedef struct packed {
    logic        r_sign;
    logic [31:0] r_num;
    logic [31:0] r_den;
    logic        greater;
    logic        equal;
    status_t     status;
  } result_t;

  typedef struct packed {
    action_t     act;
    logic        a_sign;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic        b_sign;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } request_t;

  typedef struct {
    logic        s;
    logic [63:0] n;
    logic [63:0] d;
  } frac_t;

  typedef struct {
    request_t req;
    bit       typed;
    result_t  res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  rau_in_if  in_ch ();
  rau_out_if out_ch ();

  rational_arith_unit uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  result_t pending_results[$];
  int      error_count = 0;
  longint unsigned cycle_count = 0;
  bit      no_idle = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Canonical results that several paths share.
  function automatic result_t zero_result(status_t st);
    result_t r;
    r = '{r_sign: 1'b0, r_num: 32'd0, r_den: 32'd1, greater: 1'b0, equal: 1'b0, status: st};
    return r;
  endfunction

  function automatic request_t in_ch_default();
    request_t q;
    q = '{ACT_NORM, 1'b0, 32'd0, 32'd1, 1'b0, 32'd0, 32'd1};
    return q;
  endfunction

  function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 64'd0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic frac_t lowest_terms(logic s, logic [63:0] n, logic [63:0] d);
    frac_t f;
    logic [63:0] g;
    if (n == 64'd0 || d == 64'd0) begin
      f = '{1'b0, 64'd0, 64'd1};
    end else begin
      g = euclid_gcd(n, d);
      f = '{s, n / g, d / g};
    end
    return f;
  endfunction

  // Reduce and range check; out-of-range values become an overflow.
  function automatic result_t fit_result(logic s, logic [63:0] n, logic [63:0] d);
    frac_t f;
    logic [63:0] top;
    result_t r;
    top = (64'd1 << VW) - 64'd1;
    f = lowest_terms(s, n, d);
    if (f.n > top || f.d > top) return zero_result(ST_OVF);
    r = zero_result(ST_OK);
    r.r_sign = f.s;
    r.r_num = f.n[31:0];
    r.r_den = f.d[31:0];
    return r;
  endfunction

  function automatic result_t frac_sum(frac_t a, frac_t b);
    logic [63:0] g, ad, bd, x, y, t, g2;
    logic [64:0] wide;
    logic s;
    if (a.n == 64'd0) return fit_result(b.s, b.n, b.d);
    if (b.n == 64'd0) return fit_result(a.s, a.n, a.d);
    g = euclid_gcd(a.d, b.d);
    ad = a.d / g;
    bd = b.d / g;
    x = a.n * bd;
    y = b.n * ad;
    if (a.s == b.s) begin
      wide = {1'b0, x} + {1'b0, y};
      if (wide[64]) return zero_result(ST_OVF);
      t = wide[63:0];
      s = a.s;
    end else if (x >= y) begin
      t = x - y;
      s = a.s;
    end else begin
      t = y - x;
      s = b.s;
    end
    if (t == 64'd0) return zero_result(ST_OK);
    g2 = euclid_gcd(t, g);
    return fit_result(s, t / g2, ad * (b.d / g2));
  endfunction

  function automatic result_t frac_product(frac_t a, frac_t b);
    if (a.n == 64'd0 || b.n == 64'd0) return zero_result(ST_OK);
    return fit_result(a.s != b.s, a.n * b.n, a.d * b.d);
  endfunction

  // Expected result of one transaction.
  function automatic result_t rational_result(request_t q);
    logic [63:0] top, an, ad, bn, bd, x, y;
    frac_t a, b, inv;
    bit unary;
    result_t r;
    top = (64'd1 << VW) - 64'd1;
    an = {32'd0, q.a_num} & top;
    ad = {32'd0, q.a_den} & top;
    bn = {32'd0, q.b_num} & top;
    bd = {32'd0, q.b_den} & top;
    unary = (q.act == ACT_NORM || q.act == ACT_NEG || q.act == ACT_RCP);
    if (ad == 64'd0 || (!unary && bd == 64'd0)) return zero_result(ST_ZERODEN);
    a = lowest_terms(q.a_sign, an, ad);
    b = unary ? lowest_terms(1'b0, 64'd0, 64'd1) : lowest_terms(q.b_sign, bn, bd);
    case (q.act)
      ACT_NORM: r = fit_result(a.s, a.n, a.d);
      ACT_ADD:  r = frac_sum(a, b);
      ACT_SUB: begin
        if (b.n != 64'd0) b.s = !b.s;
        r = frac_sum(a, b);
      end
      ACT_MUL:  r = frac_product(a, b);
      ACT_DIV: begin
        if (b.n == 64'd0) begin
          r = zero_result(ST_DIVZERO);
        end else begin
          inv = '{b.s, b.d, b.n};
          r = frac_product(a, inv);
        end
      end
      ACT_CMP: begin
        x = a.n * b.d;
        y = b.n * a.d;
        r = zero_result(ST_OK);
        if (a.s != b.s) begin
          r.greater = !a.s;
        end else begin
          r.equal = (x == y);
          r.greater = a.s ? (x < y) : (x > y);
        end
      end
      ACT_NEG:  r = fit_result((a.n != 64'd0) ? !a.s : 1'b0, a.n, a.d);
      default: begin
        if (a.n == 64'd0) r = zero_result(ST_DIVZERO);
        else r = fit_result(a.s, a.d, a.n);
      end
    endcase
    return r;
  endfunction

  // Random operand magnitude: mostly small, sometimes full width or edge values.
  function automatic logic [31:0] rand_mag();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 40);
      4, 5:       return $urandom_range(0, 5000);
      6:          return $urandom_range(0, 32'hFFFF);
      7:          return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default:    return $urandom();
    endcase
  endfunction

  function automatic request_t rand_request();
    request_t q;
    logic [31:0] k;
    q.act = action_t'($urandom_range(0, 7));
    q.a_sign = 1'($urandom_range(0, 1));
    q.b_sign = 1'($urandom_range(0, 1));
    q.a_num = rand_mag();
    q.b_num = rand_mag();
    q.a_den = rand_mag();
    q.b_den = rand_mag();
    // Zero denominators only now and then.
    if (q.a_den == 32'd0 && $urandom_range(0, 3) != 0) q.a_den = 32'd1;
    if (q.b_den == 32'd0 && $urandom_range(0, 3) != 0) q.b_den = 32'd7;
    // Equal values with different forms, to reach the equality paths.
    if ($urandom_range(0, 7) == 0) begin
      k = $urandom_range(1, 9);
      q.b_sign = q.a_sign;
      q.b_num = q.a_num * k;
      q.b_den = q.a_den * k;
    end
    return q;
  endfunction

  // Drive one transaction and wait for it to be taken.
  task automatic send(request_t q);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.action = q.act;
    in_ch.a_sign = q.a_sign;
    in_ch.a_num = q.a_num;
    in_ch.a_den = q.a_den;
    in_ch.b_sign = q.b_sign;
    in_ch.b_num = q.b_num;
    in_ch.b_den = q.b_den;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Expectations are queued at the edge where the input transaction is taken.
  stim_row_t live_row;
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (live_row.typed) pending_results.push_back(live_row.res);
      else pending_results.push_back(rational_result(live_row.req));
    end
  end

  // Compare each output transaction with the oldest expectation.
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.r_sign, out_ch.r_num, out_ch.r_den, out_ch.greater, out_ch.equal,
              status_t'(out_ch.status)};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.r_sign !== want.r_sign || got.r_num !== want.r_num ||
            got.r_den !== want.r_den || got.greater !== want.greater ||
            got.equal !== want.equal || got.status !== want.status) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          error_count++;
        end
      end
    end
  end

  // Result side stalls at random per transaction, except in no-idle stretches.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_tab[] = '{
      '{'{ACT_NORM, 1'b0, 32'd6, 32'd4, 1'b0, 32'd0, 32'd1}, 1'b1,
        '{1'b0, 32'd3, 32'd2, 1'b0, 1'b0, ST_OK}},
      '{'{ACT_NORM, 1'b1, 32'd0, 32'd9, 1'b0, 32'd0, 32'd1}, 1'b1, zero_result(ST_OK)},
      '{'{ACT_NORM, 1'b0, 32'd5, 32'd0, 1'b0, 32'd0, 32'd1}, 1'b1, zero_result(ST_ZERODEN)},
      '{'{ACT_ADD, 1'b0, 32'd1, 32'd2, 1'b1, 32'd3, 32'd0}, 1'b1, zero_result(ST_ZERODEN)},
      '{'{ACT_NEG, 1'b0, 32'd4, 32'd8, 1'b1, 32'd3, 32'd0}, 1'b1,
        '{1'b1, 32'd1, 32'd2, 1'b0, 1'b0, ST_OK}},
      '{'{ACT_DIV, 1'b0, 32'd3, 32'd5, 1'b1, 32'd0, 32'd7}, 1'b1, zero_result(ST_DIVZERO)},
      '{'{ACT_RCP, 1'b1, 32'd0, 32'd3, 1'b0, 32'd0, 32'd1}, 1'b1, zero_result(ST_DIVZERO)},
      '{'{ACT_MUL, 1'b0, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'hFFFF_FFFF, 32'd1}, 1'b1,
        zero_result(ST_OVF)},
      '{'{ACT_ADD, 1'b0, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'hFFFF_FFFF, 32'd1}, 1'b1,
        zero_result(ST_OVF)},
      '{'{ACT_SUB, 1'b1, 32'd7, 32'd3, 1'b1, 32'd14, 32'd6}, 1'b1, zero_result(ST_OK)},
      '{'{ACT_RCP, 1'b1, 32'd6, 32'd4, 1'b0, 32'd0, 32'd1}, 1'b1,
        '{1'b1, 32'd2, 32'd3, 1'b0, 1'b0, ST_OK}},
      '{'{ACT_ADD, 1'b0, 32'd1, 32'd3, 1'b1, 32'd1, 32'd6}, 1'b0, zero_result(ST_OK)},
      '{'{ACT_SUB, 1'b0, 32'd1, 32'hFFFF_FFFF, 1'b0, 32'd1, 32'hFFFF_FFFE}, 1'b0,
        zero_result(ST_OK)},
      '{'{ACT_MUL, 1'b1, 32'd10, 32'd21, 1'b0, 32'd14, 32'd15}, 1'b0, zero_result(ST_OK)},
      '{'{ACT_DIV, 1'b1, 32'd2, 32'd3, 1'b1, 32'd4, 32'd9}, 1'b0, zero_result(ST_OK)},
      '{'{ACT_DIV, 1'b0, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'd1, 32'hFFFF_FFFF}, 1'b0,
        zero_result(ST_OK)},
      '{'{ACT_CMP, 1'b0, 32'd1, 32'd2, 1'b0, 32'd2, 32'd4}, 1'b0, zero_result(ST_OK)},
      '{'{ACT_CMP, 1'b1, 32'd1, 32'd2, 1'b1, 32'd1, 32'd3}, 1'b0, zero_result(ST_OK)},
      '{'{ACT_CMP, 1'b1, 32'd0, 32'd5, 1'b0, 32'd0, 32'd2}, 1'b0, zero_result(ST_OK)},
      '{'{ACT_CMP, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'd3, 32'd1}, 1'b0,
        zero_result(ST_OK)},
      '{'{ACT_NEG, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0}, 1'b0,
        zero_result(ST_OK)},
      '{'{ACT_NORM, 1'b1, 32'h8000_0000, 32'h0001_0000, 1'b0, 32'd0, 32'd0}, 1'b0,
        zero_result(ST_OK)}
    };
    request_t q;

    in_ch.valid = 1'b0;
    in_ch.action = ACT_NORM;
    in_ch.a_sign = 1'b0;
    in_ch.a_num = 32'd0;
    in_ch.a_den = 32'd1;
    in_ch.b_sign = 1'b0;
    in_ch.b_num = 32'd0;
    in_ch.b_den = 32'd1;
    live_row = '{in_ch_default(), 1'b0, zero_result(ST_OK)};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table.
    foreach (dir_tab[i]) begin
      live_row = dir_tab[i];
      send(dir_tab[i].req);
    end

    // Hold off until every directed result is back.
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);

    // Random part, with no-idle stretches now and then.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 0) no_idle = ($urandom_range(0, 2) == 0);
      q = rand_request();
      live_row = '{q, 1'b0, zero_result(ST_OK)};
      send(q);
    end
    in_ch.valid = 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rau_pkg.sv
rtl/core/rau_if.sv
rtl/core/rau_divider.sv
rtl/core/rational_arith_unit.sv
dv/testbench.sv
